// ===== src/toh_pkg.sv =====
// Package for the 2-opt hill climb block: sizes, payload structs, command codes.
// Used by toh_ctrl, toh_dp and two_opt_hill_climb_top.
package toh_pkg;
   localparam int MaxCities = 64;
   localparam int CityBits = 6;
   localparam int DistBits = 16;
   localparam int LenBits = 22;
   localparam int SumBits = 24;
   localparam int CfgBits = 16;
   localparam int CountBits = 7;

   localparam logic [1:0] KIND_DIST = 2'd0;
   localparam logic [1:0] KIND_TOUR = 2'd1;
   localparam logic [1:0] KIND_RUN  = 2'd2;
   localparam logic [1:0] KIND_SKIP = 2'd3;

   localparam logic CSR_CITY_COUNT = 1'b0;
   localparam logic CSR_ITER_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0]          kind;
      logic [CityBits-1:0] from_city;
      logic [CityBits-1:0] to_city;
      logic [DistBits-1:0] distance;
      logic [CityBits-1:0] tour_position;
      logic [CityBits-1:0] tour_city;
   } req_type;

   typedef struct packed {
      logic [CityBits-1:0] position;
      logic [CityBits-1:0] city;
      logic [LenBits-1:0]  tour_length;
      logic                last;
   } rsp_type;

   // datapath command set
   typedef enum logic [3:0] {
      OP_NONE, OP_LEN_CLR, OP_LEN_RD, OP_LEN_ACC,
      OP_MV_RD, OP_MV_ACC, OP_SWAP_RD, OP_SWAP_WR, OP_OUT
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CityBits-1:0] a;
      logic [CityBits-1:0] b;
      logic                phase;
      logic                apply;
      logic [CityBits-1:0] n_m1;
   } cmd_type;

   typedef struct packed {
      logic improve;
   } sts_type;
endpackage

// ===== src/two_opt_hill_climb_top.sv =====
// Top level of the 2-opt hill climb: CSRs, controller and datapath.
// Load transactions leave busy low. A run measures the tour length, tries moves and swaps
// the segment of each improving one, then gives n results on consecutive cycles, each in
// the cycle after its tour read; busy covers the last one. One run at a time, set by the
// single distance read port; the receiver cannot stall. Synchronous reset clears control
// state; stores hold garbage until written.
module two_opt_hill_climb_top
   import toh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [CfgBits-1:0] csr_wdata
);
   logic [CountBits-1:0] city_count_ff;
   logic [CfgBits-1:0]   iter_limit_ff;
   logic                 acc, run;
   cmd_type              cmd;
   sts_type              sts;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= CountBits'(MaxCities);
         iter_limit_ff <= CfgBits'(1000);
      end else if (csr_we) begin
         case (csr_index)
            CSR_CITY_COUNT: city_count_ff <= csr_wdata[CountBits-1:0];
            CSR_ITER_LIMIT: iter_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign acc = start && !busy;
   assign run = acc && req_data.kind == KIND_RUN;

   toh_ctrl u_ctrl (
      .clock(clock), .reset(reset), .run(run), .city_count(city_count_ff),
      .iter_limit(iter_limit_ff), .sts(sts), .cmd(cmd), .busy(busy),
      .rsp_valid(rsp_valid)
   );

   toh_dp u_dp (
      .clock(clock), .reset(reset), .load_en(acc), .load(req_data),
      .cmd(cmd), .sts(sts), .rsp_out(rsp_data)
   );
endmodule

// ===== src/toh_dp.sv =====
// Datapath: distance memory, tour registers, edge fetch and gain accumulation.
// Depends on toh_pkg; driven by toh_ctrl through cmd_type.
module toh_dp
   import toh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load_en,
   input  req_type load,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_out
);
   logic [DistBits-1:0] dmem [MaxCities*MaxCities];
   logic [CityBits-1:0] tour_ff [MaxCities];
   logic [CityBits-1:0] ta_ff, tb_ff;
   op_type              t_op_ff;
   logic                t_ph_ff;
   logic [DistBits-1:0] rd_ff;
   logic                rd_vld_ff, rd_vld_in;
   op_type              rd_op_ff;
   logic                rd_ph_ff;
   logic [SumBits-1:0]  len_ff, len_in;
   logic [SumBits-1:0]  sub_ff, sub_in, add_ff, add_in;
   logic [CityBits-1:0] out_pos_ff;
   logic                out_last_ff;
   logic [2*CityBits-1:0] raddr;
   logic [LenBits-1:0]  sat_len;

   // read the tour cities of the current edge into registers
   always_ff @(posedge clock) begin
      if (reset) begin
         t_op_ff <= OP_NONE;
      end else begin
         t_op_ff <= cmd.op;
      end
      ta_ff <= tour_ff[cmd.a];
      tb_ff <= tour_ff[cmd.b];
      t_ph_ff <= cmd.phase;
      out_pos_ff <= cmd.a;
      out_last_ff <= cmd.a == cmd.n_m1;
   end

   assign raddr = {ta_ff, tb_ff};

   // distance memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (load_en && load.kind == KIND_DIST) begin
         dmem[{load.from_city, load.to_city}] <= load.distance;
      end
      rd_ff <= dmem[raddr];
      rd_op_ff <= t_op_ff;
      rd_ph_ff <= t_ph_ff;
   end

   assign rd_vld_in = (t_op_ff == OP_LEN_RD) || (t_op_ff == OP_MV_RD);

   // clear and accumulate length and move sums from the registered read; apply a gain to the length
   always_comb begin
      len_in = len_ff;
      sub_in = sub_ff;
      add_in = add_ff;
      if (cmd.op == OP_LEN_CLR) begin
         len_in = '0;
      end else if (cmd.op == OP_MV_ACC && !cmd.phase && cmd.a == '0) begin
         sub_in = '0;
         add_in = '0;
      end
      if (rd_vld_ff && rd_op_ff == OP_LEN_RD) begin
         len_in = len_ff + SumBits'(rd_ff);
      end else if (rd_vld_ff && rd_op_ff == OP_MV_RD) begin
         if (rd_ph_ff) add_in = add_ff + SumBits'(rd_ff);
         else          sub_in = sub_ff + SumBits'(rd_ff);
      end
      if (cmd.apply) len_in = len_ff - (sub_ff - add_ff);
   end

   assign sts.improve = add_ff < sub_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         len_ff <= '0;
      end else begin
         rd_vld_ff <= rd_vld_in;
         len_ff <= len_in;
      end
      sub_ff <= sub_in;
      add_ff <= add_in;
   end

   // tour: load writes and segment swaps from the registered reads
   always_ff @(posedge clock) begin
      if (cmd.op == OP_SWAP_WR) begin
         tour_ff[cmd.a] <= tb_ff;
         tour_ff[cmd.b] <= ta_ff;
      end else if (load_en && load.kind == KIND_TOUR) begin
         tour_ff[load.tour_position] <= load.tour_city;
      end
   end

   assign sat_len = (len_ff > SumBits'({LenBits{1'b1}})) ? {LenBits{1'b1}}
                    : len_ff[LenBits-1:0];

   // result fields, in the cycle after the output command
   always_comb begin
      rsp_out.position = out_pos_ff;
      rsp_out.city = ta_ff;
      rsp_out.tour_length = sat_len;
      rsp_out.last = out_last_ff;
   end
endmodule

// ===== src/toh_ctrl.sv =====
// Controller: sequences length measurement, move scan, swaps and output.
// Depends on toh_pkg; commands toh_dp.
module toh_ctrl
   import toh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               run,
   input  logic [CountBits-1:0] city_count,
   input  logic [CfgBits-1:0] iter_limit,
   input  sts_type            sts,
   output cmd_type            cmd,
   output logic               busy,
   output logic               rsp_valid
);
   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001, S_LEN = 9'b000000010, S_LWAIT = 9'b000000100,
      S_SCAN = 9'b000001000, S_SWAIT = 9'b000010000, S_EVAL = 9'b000100000,
      S_SWRD = 9'b001000000, S_SWWR = 9'b010000000, S_OUT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [CityBits-1:0] n_m1_ff, n_m1_in, i_ff, i_in, j_ff, j_in;
   logic [CityBits-1:0] k_ff, k_in, a_ff, a_in, b_ff, b_in, ka, kb;
   logic                ph_ff, ph_in;
   logic [CfgBits-1:0]  mv_ff, mv_in;
   logic [1:0]          w_ff, w_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CountBits-1:0] nc;
   logic [CityBits-1:0] nx;

   assign nc = (city_count == '0) ? CountBits'(1)
             : (city_count > CountBits'(MaxCities)) ? CountBits'(MaxCities) : city_count;
   assign nx = (j_ff == n_m1_ff) ? '0 : j_ff + 1'b1;

   // move terms in k order: k=0: e(i-1,i)/e(i-1,j); k=1: e(j,nx)/e(i,nx);
   // k>=2: fw edge (m-1,m) / rv edge (m,m-1) for m = i+k-1 in (i, j]
   always_comb begin
      ka = '0; kb = '0;
      if (k_ff == '0) begin
         ka = i_ff - 1'b1; kb = ph_ff ? j_ff : i_ff;
      end else if (k_ff == CityBits'(1)) begin
         ka = ph_ff ? i_ff : j_ff; kb = nx;
      end else begin
         ka = ph_ff ? i_ff + k_ff - 1'b1 : i_ff + k_ff - 2'd2;
         kb = ph_ff ? i_ff + k_ff - 2'd2 : i_ff + k_ff - 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff; n_m1_in = n_m1_ff; i_in = i_ff; j_in = j_ff;
      k_in = k_ff; a_in = a_ff; b_in = b_ff; ph_in = ph_ff; mv_in = mv_ff; w_in = w_ff;
      cmd = '0;
      cmd.op = OP_NONE;
      cmd.n_m1 = n_m1_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (run) begin
               n_m1_in = CityBits'(nc - 1'b1);
               k_in = '0; mv_in = '0;
               cmd.op = OP_LEN_CLR;
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            cmd.op = OP_LEN_RD;
            cmd.a = k_ff;
            cmd.b = (k_ff == n_m1_ff) ? '0 : k_ff + 1'b1;
            k_in = k_ff + 1'b1;
            if (k_ff == n_m1_ff) begin
               w_in = 2'd2; state_in = S_LWAIT;
            end
         end
         S_LWAIT: begin
            w_in = w_ff - 1'b1;
            if (w_ff == 2'd1) begin
               // clear the move sums ahead of the first scan
               cmd.op = OP_MV_ACC;
               i_in = CityBits'(1); j_in = CityBits'(2); k_in = '0; ph_in = 1'b0;
               if (n_m1_ff < CityBits'(2) || iter_limit == '0) begin
                  k_in = '0; state_in = S_OUT;
               end else state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // read one move term per cycle: removed edges, then added edges
            cmd.op = OP_MV_RD;
            cmd.a = ka; cmd.b = kb; cmd.phase = ph_ff;
            k_in = k_ff + 1'b1;
            if (k_ff == j_ff - i_ff + 1'b1) begin
               k_in = '0;
               if (!ph_ff) begin
                  ph_in = 1'b1;
               end else begin
                  w_in = 2'd2; state_in = S_SWAIT;
               end
            end
         end
         S_SWAIT: begin
            w_in = w_ff - 1'b1;
            if (w_ff == 2'd1) state_in = S_EVAL;
         end
         S_EVAL: begin
            if (sts.improve) begin
               cmd.apply = 1'b1;
               a_in = i_ff; b_in = j_ff;
               mv_in = mv_ff + 1'b1;
               state_in = S_SWRD;
            end else begin
               // clear the move sums for the next pair
               cmd.op = OP_MV_ACC;
               k_in = '0; ph_in = 1'b0;
               if (j_ff == n_m1_ff) begin
                  if (i_ff == n_m1_ff - 1'b1) begin
                     k_in = '0; state_in = S_OUT;
                  end else begin
                     i_in = i_ff + 1'b1; j_in = i_ff + 2'd2; state_in = S_SCAN;
                  end
               end else begin
                  j_in = j_ff + 1'b1; state_in = S_SCAN;
               end
            end
         end
         S_SWRD: begin
            if (a_ff < b_ff) begin
               cmd.op = OP_SWAP_RD; cmd.a = a_ff; cmd.b = b_ff;
               state_in = S_SWWR;
            end else begin
               cmd.op = OP_MV_ACC;
               i_in = CityBits'(1); j_in = CityBits'(2); k_in = '0; ph_in = 1'b0;
               if (mv_ff == iter_limit) begin
                  state_in = S_OUT;
               end else state_in = S_SCAN;
            end
         end
         S_SWWR: begin
            cmd.op = OP_SWAP_WR; cmd.a = a_ff; cmd.b = b_ff;
            a_in = a_ff + 1'b1; b_in = b_ff - 1'b1;
            state_in = S_SWRD;
         end
         S_OUT: begin
            cmd.op = OP_OUT; cmd.a = k_ff;
            rsp_valid_in = 1'b1;
            k_in = k_ff + 1'b1;
            if (k_ff == n_m1_ff) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mv_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mv_ff <= mv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_m1_ff <= n_m1_in; i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      a_ff <= a_in; b_ff <= b_in; ph_ff <= ph_in; w_ff <= w_in;
   end

   // check: output stays inside the tour, state is one-hot, scans never pass the limit or an empty segment
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> k_ff <= n_m1_ff) else $error("output past tour end");
   assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> mv_ff < iter_limit) else $error("scan beyond limit");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> j_ff > i_ff) else $error("empty segment scanned");
endmodule

// ===== tb/two_opt_hill_climb_checker.sv =====
// Checker for the 2-opt hill climb: mirrors the distance and tour stores,
// predicts each climb and compares the emitted tour. Depends on toh_pkg.
`timescale 1ns / 1ps
module two_opt_hill_climb_checker
   import toh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [CfgBits-1:0] csr_wdata,
   output int                 fail_count,
   output int                 pending,
   output int                 run_count,
   output int                 rsp_count
);
   logic [DistBits-1:0]  dist_mem [MaxCities][MaxCities];
   logic [CityBits-1:0]  tour_mem [MaxCities];
   logic [CountBits-1:0] city_cnt;
   logic [15:0]          iter_lim;
   rsp_type              tour_q[$];

   assign pending = tour_q.size();

   function automatic longint hop(int a, int b);
      return longint'(dist_mem[tour_mem[a]][tour_mem[b]]);
   endfunction

   // Climb on the mirrored tour and queue the final tour, one entry per position
   function automatic void climb_tour();
      int n, i, j, nx, a, b, moves;
      longint len, sub, add;
      longint fw[MaxCities];
      longint rv[MaxCities];
      bit found;
      logic [CityBits-1:0] t;
      logic [LenBits-1:0] olen;
      rsp_type e;
      n = (city_cnt == 0) ? 1 : ((city_cnt > MaxCities) ? MaxCities : int'(city_cnt));
      len = 0;
      for (int k = 0; k < n; k++) len += hop(k, (k + 1) % n);
      moves = 0;
      while (moves < int'(iter_lim)) begin
         found = 0;
         fw[0] = 0;
         rv[0] = 0;
         for (int k = 1; k < n; k++) begin
            fw[k] = fw[k-1] + hop(k - 1, k);
            rv[k] = rv[k-1] + hop(k, k - 1);
         end
         for (i = 1; i + 1 < n && !found; i++) begin
            for (j = i + 1; j < n && !found; j++) begin
               nx = (j + 1) % n;
               sub = hop(i - 1, i) + hop(j, nx) + (fw[j] - fw[i]);
               add = hop(i - 1, j) + hop(i, nx) + (rv[j] - rv[i]);
               if (add < sub) begin
                  a = i;
                  b = j;
                  while (a < b) begin
                     t = tour_mem[a];
                     tour_mem[a] = tour_mem[b];
                     tour_mem[b] = t;
                     a++;
                     b--;
                  end
                  len -= (sub - add);
                  found = 1;
               end
            end
         end
         if (!found) break;
         moves++;
      end
      olen = (len > 64'd4194303) ? '1 : len[LenBits-1:0];
      for (int k = 0; k < n; k++) begin
         e.position = k[CityBits-1:0];
         e.city = tour_mem[k];
         e.tour_length = olen;
         e.last = (k == n - 1);
         tour_q.insert(tour_q.size(), e);
      end
   endfunction

   task automatic report(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      run_count = 0;
      rsp_count = 0;
   end

   // Track config and load transactions, predict on every run
   always @(posedge clock) begin
      if (reset) begin
         city_cnt = 7'd64;
         iter_lim = 16'd1000;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CITY_COUNT) city_cnt = csr_wdata[CountBits-1:0];
            else iter_lim = csr_wdata;
         end
         if (start && !busy) begin
            case (req_data.kind)
               KIND_DIST: dist_mem[req_data.from_city][req_data.to_city] = req_data.distance;
               KIND_TOUR: tour_mem[req_data.tour_position] = req_data.tour_city;
               KIND_RUN: begin
                  climb_tour();
                  run_count++;
               end
               default: ;
            endcase
         end
      end
   end

   // Compare each result transaction with the oldest expected tour entry
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         rsp_count++;
         if (tour_q.size() == 0) begin
            report($sformatf("unexpected result pos %0d city %0d",
                             rsp_data.position, rsp_data.city));
         end else begin
            e = tour_q.pop_front();
            if (rsp_data.position !== e.position)
               report($sformatf("position %0d, want %0d", rsp_data.position, e.position));
            if (rsp_data.city !== e.city)
               report($sformatf("city %0d at pos %0d, want %0d",
                                rsp_data.city, e.position, e.city));
            if (rsp_data.tour_length !== e.tour_length)
               report($sformatf("tour_length %0d at pos %0d, want %0d",
                                rsp_data.tour_length, e.position, e.tour_length));
            if (rsp_data.last !== e.last)
               report($sformatf("last %0b at pos %0d, want %0b",
                                rsp_data.last, e.position, e.last));
         end
      end
   end
endmodule

// ===== tb/two_opt_hill_climb_top_tb.sv =====
// Testbench top for two_opt_hill_climb_top: clock, reset, stimulus, verdict.
// Depends on toh_pkg and two_opt_hill_climb_checker.
`timescale 1ns / 1ps
module two_opt_hill_climb_top_tb;
   import toh_pkg::*;

   localparam int QuietLimit = 3000000;
   localparam int FillCities = 10;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_we;
   logic               csr_index;
   logic [CfgBits-1:0] csr_wdata;
   int                 fail_count, pending, run_count, rsp_count;
   int                 idle_pct;
   int                 item_cnt;
   int                 quiet_cycles;
   logic [CityBits-1:0] perm [MaxCities];

   two_opt_hill_climb_top dut (.*);

   two_opt_hill_climb_checker u_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_we, .csr_index, .csr_wdata, .fail_count, .pending, .run_count, .rsp_count
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Hold start until the block takes the transaction, then maybe idle
   task automatic send(input req_type r);
      int gap;
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if (r.kind != KIND_SKIP) item_cnt++;
      if ($urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 4);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
            req_data <= req_type'($urandom);
         end
      end
   endtask

   task automatic load_dist(input int r, input int c, input int d);
      req_type q;
      q = req_type'({$urandom, $urandom});
      q.kind = KIND_DIST;
      q.from_city = r[CityBits-1:0];
      q.to_city = c[CityBits-1:0];
      q.distance = d[DistBits-1:0];
      send(q);
   endtask

   task automatic load_tour(input int p, input int c);
      req_type q;
      q = req_type'({$urandom, $urandom});
      q.kind = KIND_TOUR;
      q.tour_position = p[CityBits-1:0];
      q.tour_city = c[CityBits-1:0];
      send(q);
   endtask

   task automatic run_climb();
      req_type q;
      q = req_type'({$urandom, $urandom});
      q.kind = KIND_RUN;
      send(q);
   endtask

   task automatic send_noise();
      req_type q;
      q = req_type'({$urandom, $urandom});
      q.kind = KIND_SKIP;
      send(q);
   endtask

   // Drain all results and let the block settle before touching registers
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input int val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CfgBits-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int n, lim, nwr, sel, t;
      logic [CityBits-1:0] sw;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_CITY_COUNT;
      csr_wdata = '0;
      idle_pct = 0;
      item_cnt = 0;
      quiet_cycles = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Fill a dense corner of the matrix, a ring through all cities and an identity
      // tour, so that no climb reads an unwritten entry
      for (int r = 0; r < FillCities; r++)
         for (int c = 0; c < FillCities; c++)
            load_dist(r, c, $urandom_range(0, 65535));
      for (int k = FillCities - 1; k < MaxCities; k++)
         load_dist(k, (k + 1) % MaxCities, $urandom_range(0, 65535));
      for (int p = 0; p < MaxCities; p++) load_tour(p, p);

      // Directed: field extremes, unused kind, degenerate sizes and limits
      idle_pct = 20;
      load_dist(63, 63, 65535);
      load_dist(0, 0, 0);
      load_dist(0, 63, 65535);
      load_tour(63, 63);
      load_tour(0, 0);
      send_noise();
      wait_idle();
      csr_write(CSR_ITER_LIMIT, 0);
      csr_write(CSR_CITY_COUNT, 0);          // treated as one city
      run_climb();
      wait_idle();
      csr_write(CSR_CITY_COUNT, 2);
      run_climb();
      wait_idle();
      csr_write(CSR_CITY_COUNT, 127);        // clamps to the maximum
      run_climb();                           // zero limit: starting tour
      wait_idle();
      csr_write(CSR_CITY_COUNT, FillCities);
      csr_write(CSR_ITER_LIMIT, 1);
      run_climb();
      wait_idle();
      csr_write(CSR_CITY_COUNT, 3);
      csr_write(CSR_ITER_LIMIT, 65535);
      load_tour(0, 5);
      load_tour(1, 5);                       // repeated city
      load_tour(2, 9);
      run_climb();
      wait_idle();
      csr_write(CSR_CITY_COUNT, FillCities);
      csr_write(CSR_ITER_LIMIT, 2);
      run_climb();
      wait_idle();

      // Random: mostly complete problems with random content, some noise
      while (item_cnt < 500) begin
         case ($urandom_range(0, 3))
            0: idle_pct = 0;
            1: idle_pct = 49;
            2: idle_pct = 0;
            default: idle_pct = 35;
         endcase
         sel = $urandom_range(0, 99);
         n = (sel < 90) ? $urandom_range(3, FillCities) : $urandom_range(1, 2);
         lim = ($urandom_range(0, 9) < 7) ? $urandom_range(100, 65535) : $urandom_range(0, 5);
         csr_write(CSR_CITY_COUNT, n);
         csr_write(CSR_ITER_LIMIT, lim);
         for (int k = 0; k < MaxCities; k++) perm[k] = k[CityBits-1:0];
         for (int k = FillCities - 1; k > 0; k--) begin
            t = $urandom_range(0, k);
            sw = perm[k];
            perm[k] = perm[t];
            perm[t] = sw;
         end
         if ($urandom_range(0, 9) == 0) perm[$urandom_range(0, n - 1)] = perm[0];
         for (int p = 0; p < n; p++) load_tour(p, perm[p]);
         nwr = $urandom_range(0, 3 * n);
         for (int w = 0; w < nwr; w++) begin
            case ($urandom_range(0, 9))
               0: t = 0;
               1: t = 65535;
               default: t = $urandom_range(0, 65535);
            endcase
            if ($urandom_range(0, 3) == 0)
               load_dist($urandom_range(0, 63), $urandom_range(0, 63), t);
            else
               load_dist(perm[$urandom_range(0, n - 1)], perm[$urandom_range(0, n - 1)], t);
         end
         if ($urandom_range(0, 4) == 0) send_noise();
         run_climb();
         wait_idle();
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("Covered %0d climbs and %0d tour results, sizes 1 to 64, limits 0 to 65535",
               run_count, rsp_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
